@@ src/lrast_pkg.sv @@
`default_nettype none

package lrast_pkg;

   // fixed payload widths
   localparam int COLOR_W = 24;

   // action codes carried on the request beat
   typedef enum logic {
      ACT_START = 1'b0,
      ACT_STEP  = 1'b1
   } act_type;

   // octant flags kept for the line in progress
   typedef struct packed {
      logic y_major;
      logic y_neg;
   } dirs_type;

endpackage

`default_nettype wire

@@ src/lrast_req_if.sv @@
`default_nettype none

interface lrast_req_if #(
   parameter int COORD_W = 9
) ();
   import lrast_pkg::*;

   logic               valid;
   logic               ready;
   logic               action;
   logic [COORD_W-1:0] start_x;
   logic [COORD_W-1:0] start_y;
   logic [COORD_W-1:0] end_x;
   logic [COORD_W-1:0] end_y;
   logic [COLOR_W-1:0] color;

   modport source (
      output valid, action, start_x, start_y, end_x, end_y, color,
      input  ready
   );

   modport sink (
      input  valid, action, start_x, start_y, end_x, end_y, color,
      output ready
   );
endinterface

`default_nettype wire

@@ src/lrast_rsp_if.sv @@
`default_nettype none

interface lrast_rsp_if #(
   parameter int COORD_W = 9
) ();
   import lrast_pkg::*;

   logic               valid;
   logic               ready;
   logic [COORD_W-1:0] pixel_x;
   logic [COORD_W-1:0] pixel_y;
   logic [COLOR_W-1:0] pixel_color;
   logic               last_pixel;

   modport source (
      output valid, pixel_x, pixel_y, pixel_color, last_pixel,
      input  ready
   );

   modport sink (
      input  valid, pixel_x, pixel_y, pixel_color, last_pixel,
      output ready
   );
endinterface

`default_nettype wire

@@ src/lrast_setup.sv @@
`default_nettype none

module lrast_setup #(
   parameter int COORD_W = 9
) (
   input  wire logic [COORD_W-1:0]   x0,
   input  wire logic [COORD_W-1:0]   y0,
   input  wire logic [COORD_W-1:0]   x1,
   input  wire logic [COORD_W-1:0]   y1,
   output logic [COORD_W-1:0]        first_x,
   output logic [COORD_W-1:0]        first_y,
   output logic [COORD_W-1:0]        stop_major,
   output logic [COORD_W-1:0]        delta_major,
   output logic [COORD_W-1:0]        delta_minor,
   output logic signed [COORD_W+2:0] error_init,
   output lrast_pkg::dirs_type       dirs
);
   import lrast_pkg::*;

   logic               swap;
   logic [COORD_W-1:0] ax, ay, bx, by;
   logic [COORD_W-1:0] dx, dy;
   logic               yneg;
   logic               ymaj;

   always_comb begin
      // walk left to right: swap when the first endpoint lies to the right
      swap = (x0 > x1);
      ax   = swap ? x1 : x0;
      ay   = swap ? y1 : y0;
      bx   = swap ? x0 : x1;
      by   = swap ? y0 : y1;
      dx   = bx - ax;
      yneg = (by < ay);
      dy   = yneg ? (ay - by) : (by - ay);
      ymaj = (dy > dx);

      first_x      = ax;
      first_y      = ay;
      dirs.y_major = ymaj;
      dirs.y_neg   = yneg;
      delta_major  = ymaj ? dy : dx;
      delta_minor  = ymaj ? dx : dy;
      stop_major   = ymaj ? by : bx;
      error_init   = signed'({2'b00, delta_minor, 1'b0}) - signed'({3'b000, delta_major});
   end
endmodule

`default_nettype wire

@@ src/lrast_step.sv @@
`default_nettype none

module lrast_step #(
   parameter int COORD_W = 9
) (
   input  wire logic [COORD_W-1:0]        cur_x,
   input  wire logic [COORD_W-1:0]        cur_y,
   input  wire logic signed [COORD_W+2:0] error_term,
   input  wire logic [COORD_W-1:0]        delta_major,
   input  wire logic [COORD_W-1:0]        delta_minor,
   input  wire lrast_pkg::dirs_type       dirs,
   output logic [COORD_W-1:0]             next_x,
   output logic [COORD_W-1:0]             next_y,
   output logic signed [COORD_W+2:0]      next_error
);
   import lrast_pkg::*;

   localparam logic [COORD_W-1:0] ONE = COORD_W'(1);

   logic                      minor_move;
   logic signed [COORD_W+2:0] two_major;
   logic signed [COORD_W+2:0] two_minor;
   logic [COORD_W-1:0]        x_inc;
   logic [COORD_W-1:0]        y_adv;

   always_comb begin
      // midpoint decision: a tie keeps the minor axis
      minor_move = (error_term > 0);
      two_major  = signed'({2'b00, delta_major, 1'b0});
      two_minor  = signed'({2'b00, delta_minor, 1'b0});
      next_error = error_term + two_minor - (minor_move ? two_major : '0);

      x_inc = cur_x + ONE;
      y_adv = dirs.y_neg ? (cur_y - ONE) : (cur_y + ONE);

      if (dirs.y_major) begin
         next_y = y_adv;
         next_x = minor_move ? x_inc : cur_x;
      end else begin
         next_x = x_inc;
         next_y = minor_move ? y_adv : cur_y;
      end
   end
endmodule

`default_nettype wire

@@ src/line_rasterizer_top.sv @@
// Midpoint line rasterizer, all octants, both endpoints drawn. A start beat
// (action 0) takes two endpoints and a colour and yields the first pixel; each
// step beat (action 1) yields the next pixel along the line, and the pixel on
// the far endpoint carries last_pixel. A step beat with no line in progress is
// consumed and yields nothing. A start beat always abandons any line still in
// progress. Lines are drawn left to right, so for a right-to-left line the
// first pixel is the second endpoint. Rate: one beat per clock while the response
// side keeps taking beats; a request beat is held in the request register and its
// response beat in the response register, and the pace is set by the error-term
// update loop between the two. Coordinates are $clog2(SCREEN_SIZE) bits wide.
`default_nettype none

module line_rasterizer_top #(
   parameter int SCREEN_SIZE = 512
) (
   input  wire logic   clock,
   input  wire logic   reset,
   lrast_req_if.sink   req_bus,
   lrast_rsp_if.source rsp_bus
);
   import lrast_pkg::*;

   localparam int COORD_W = $clog2(SCREEN_SIZE);
   localparam int ERR_W   = COORD_W + 3;

   // request register
   logic               in_valid_ff, in_valid_in;
   logic               in_action_ff;
   logic [COORD_W-1:0] in_x0_ff, in_y0_ff, in_x1_ff, in_y1_ff;
   logic [COLOR_W-1:0] in_color_ff;

   // line state
   logic                    active_ff, active_in;
   logic [COORD_W-1:0]      cur_x_ff, cur_x_in;
   logic [COORD_W-1:0]      cur_y_ff, cur_y_in;
   logic [COORD_W-1:0]      stop_ff, stop_in;
   logic [COORD_W-1:0]      dmaj_ff, dmaj_in;
   logic [COORD_W-1:0]      dmin_ff, dmin_in;
   logic signed [ERR_W-1:0] err_ff, err_in;
   dirs_type                dirs_ff, dirs_in;
   logic [COLOR_W-1:0]      color_ff, color_in;

   // response register
   logic               out_valid_ff, out_valid_in;
   logic [COORD_W-1:0] out_x_ff, out_y_ff;
   logic [COLOR_W-1:0] out_color_ff;
   logic               out_last_ff, out_last_in;

   // setup and step results
   logic [COORD_W-1:0]      su_x, su_y, su_stop, su_dmaj, su_dmin;
   logic signed [ERR_W-1:0] su_err;
   dirs_type                su_dirs;
   logic [COORD_W-1:0]      st_x, st_y;
   logic signed [ERR_W-1:0] st_err;

   logic is_start;
   logic produces;
   logic out_free;
   logic advance;
   logic req_beat;

   lrast_setup #(
      .COORD_W (COORD_W)
   ) u_setup (
      .x0          (in_x0_ff),
      .y0          (in_y0_ff),
      .x1          (in_x1_ff),
      .y1          (in_y1_ff),
      .first_x     (su_x),
      .first_y     (su_y),
      .stop_major  (su_stop),
      .delta_major (su_dmaj),
      .delta_minor (su_dmin),
      .error_init  (su_err),
      .dirs        (su_dirs)
   );

   lrast_step #(
      .COORD_W (COORD_W)
   ) u_step (
      .cur_x       (cur_x_ff),
      .cur_y       (cur_y_ff),
      .error_term  (err_ff),
      .delta_major (dmaj_ff),
      .delta_minor (dmin_ff),
      .dirs        (dirs_ff),
      .next_x      (st_x),
      .next_y      (st_y),
      .next_error  (st_err)
   );

   // handshake: the held beat retires when it yields nothing or the
   // response register has room, so a stalled response never blocks a
   // step beat on an idle line
   always_comb begin
      is_start  = (in_action_ff == ACT_START);
      produces  = is_start || active_ff;
      out_free  = !out_valid_ff || rsp_bus.ready;
      advance   = in_valid_ff && (!produces || out_free);
      req_bus.ready = !in_valid_ff || advance;
      req_beat  = req_bus.valid && req_bus.ready;

      if (req_beat) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   // next line state: load from setup on start, advance on step
   always_comb begin
      cur_x_in  = cur_x_ff;
      cur_y_in  = cur_y_ff;
      stop_in   = stop_ff;
      dmaj_in   = dmaj_ff;
      dmin_in   = dmin_ff;
      err_in    = err_ff;
      dirs_in   = dirs_ff;
      color_in  = color_ff;
      if (is_start) begin
         cur_x_in = su_x;
         cur_y_in = su_y;
         stop_in  = su_stop;
         dmaj_in  = su_dmaj;
         dmin_in  = su_dmin;
         err_in   = su_err;
         dirs_in  = su_dirs;
         color_in = in_color_ff;
      end else begin
         cur_x_in = st_x;
         cur_y_in = st_y;
         err_in   = st_err;
      end

      // last pixel once the major axis reaches the far endpoint
      out_last_in = dirs_in.y_major ? (cur_y_in == stop_in) : (cur_x_in == stop_in);
      active_in   = !out_last_in;

      if (advance && produces) begin
         out_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         active_ff    <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance && produces) begin
            active_ff <= active_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_beat) begin
         in_action_ff <= req_bus.action;
         in_x0_ff     <= req_bus.start_x;
         in_y0_ff     <= req_bus.start_y;
         in_x1_ff     <= req_bus.end_x;
         in_y1_ff     <= req_bus.end_y;
         in_color_ff  <= req_bus.color;
      end
      if (advance && produces) begin
         cur_x_ff     <= cur_x_in;
         cur_y_ff     <= cur_y_in;
         stop_ff      <= stop_in;
         dmaj_ff      <= dmaj_in;
         dmin_ff      <= dmin_in;
         err_ff       <= err_in;
         dirs_ff      <= dirs_in;
         color_ff     <= color_in;
         out_x_ff     <= cur_x_in;
         out_y_ff     <= cur_y_in;
         out_color_ff <= color_in;
         out_last_ff  <= out_last_in;
      end
   end

   assign rsp_bus.valid       = out_valid_ff;
   assign rsp_bus.pixel_x     = out_x_ff;
   assign rsp_bus.pixel_y     = out_y_ff;
   assign rsp_bus.pixel_color = out_color_ff;
   assign rsp_bus.last_pixel  = out_last_ff;
endmodule

`default_nettype wire

@@ src/lrast_checker.sv @@
`default_nettype none

module lrast_checker #(
   parameter int COORD_W = 9
) (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_ready,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic [COORD_W-1:0]            rsp_x,
   input wire logic [COORD_W-1:0]            rsp_y,
   input wire logic [lrast_pkg::COLOR_W-1:0] rsp_color,
   input wire logic                          rsp_last
);
   import lrast_pkg::*;

   // response beat holds while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_x) && $stable(rsp_y)
         && $stable(rsp_color) && $stable(rsp_last))
      else $error("response beat changed while stalled");

   // with the response register empty the request side cannot be blocked
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty response register");

   // reset empties the response register
   a_reset_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid straight after reset");

   // reset leaves the request side open
   a_reset_req: assert property (@(posedge clock)
      reset |=> req_ready)
      else $error("request not ready straight after reset");

   // an offered request beat only waits behind a stalled response beat
   a_req_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |-> rsp_valid && !rsp_ready)
      else $error("request stalled with no stalled response beat");
endmodule

bind line_rasterizer_top lrast_checker #(
   .COORD_W (COORD_W)
) u_lrast_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .rsp_x     (rsp_bus.pixel_x),
   .rsp_y     (rsp_bus.pixel_y),
   .rsp_color (rsp_bus.pixel_color),
   .rsp_last  (rsp_bus.last_pixel)
);

`default_nettype wire
